/* design/lcd_nibble_command_sequencer_core_assert.svh */
// Assertion macros used by the checker of the sequencer.
`ifndef LCD_NIBBLE_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define LCD_NIBBLE_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LNCS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LNCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lncs_pkg.sv */
package lncs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_WAIT  = 3'd1;
	localparam logic [2:0] CMD_BUSY  = 3'd2;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_FLUSH = 3'd4;

	localparam logic [1:0] TASK_WRITE = 2'd0;
	localparam logic [1:0] TASK_WAIT  = 2'd1;
	localparam logic [1:0] TASK_BUSY  = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_NIBBLE = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic        is_data;
		logic [15:0] value;
		logic        two_nibbles;
		logic        busy_flag;
	} request_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       rs_line;
		logic [3:0] nibble;
		logic       accepted;
		logic [4:0] pending;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        rs;
		logic        two;
		logic [15:0] val;
	} task_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_STATUS,
		EMIT_HI,
		EMIT_LO,
		EMIT_END
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CHECK,
		ST_EXEC,
		ST_LOW
	} state_t;

	typedef struct packed {
		logic  latch_req;
		logic  do_cmd;
		logic  fetch;
		logic  pop;
		logic  dec_wait;
		emit_t emit;
	} ctrl_t;

	typedef struct packed {
		logic       is_tick;
		logic       empty;
		logic [1:0] task_kind;
		logic       wait_zero;
		logic       two;
		logic       busy_flag;
	} stat_t;

endpackage

/* design/lncs_datapath.sv */
module lncs_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  lncs_pkg::request_t request,
	input  lncs_pkg::ctrl_t    ctrl,
	output lncs_pkg::stat_t    stat,
	output logic               strobe,
	output lncs_pkg::result_t  result
);

	lncs_pkg::request_t              req_q;
	lncs_pkg::task_t                 mem [lncs_pkg::QUEUE_DEPTH];
	lncs_pkg::task_t                 rd_q;
	logic [lncs_pkg::PTR_W-1:0]      head_q, head_d;
	logic [lncs_pkg::PTR_W-1:0]      tail_q, tail_d;
	logic [lncs_pkg::CNT_W-1:0]      count_q, count_d;
	logic                            strobe_q;
	lncs_pkg::result_t               result_q, res_d;
	logic                            is_enq, full, enq_ok;
	logic                            wr_en;
	logic [lncs_pkg::PTR_W-1:0]      wr_addr;
	lncs_pkg::task_t                 wr_data;

	function automatic logic [lncs_pkg::PTR_W-1:0] next_ptr(
		input logic [lncs_pkg::PTR_W-1:0] ptr
	);
		if (ptr == lncs_pkg::PTR_W'(lncs_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	assign is_enq = (req_q.command == lncs_pkg::CMD_WRITE) ||
		(req_q.command == lncs_pkg::CMD_WAIT) || (req_q.command == lncs_pkg::CMD_BUSY);
	assign full   = (count_q == lncs_pkg::CNT_W'(lncs_pkg::QUEUE_DEPTH));
	assign enq_ok = is_enq && !full;

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		wr_data = '{kind: req_q.command[1:0], rs: req_q.is_data,
			two: req_q.two_nibbles, val: req_q.value};
		if (ctrl.do_cmd) begin
			if (enq_ok) begin
				wr_en   = 1'b1;
				tail_d  = next_ptr(tail_q);
				count_d = count_q + 1'b1;
			end else if (req_q.command == lncs_pkg::CMD_FLUSH) begin
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
			end
		end
		if (ctrl.pop) begin
			head_d  = next_ptr(head_q);
			count_d = count_q - 1'b1;
		end
		if (ctrl.dec_wait) begin
			wr_en       = 1'b1;
			wr_addr     = head_q;
			wr_data     = rd_q;
			wr_data.val = rd_q.val - 16'd1;
		end
	end

	always_comb begin
		res_d          = '0;
		res_d.pending  = 5'(count_d);
		case (ctrl.emit)
			lncs_pkg::EMIT_STATUS: begin
				res_d.kind     = lncs_pkg::KIND_STATUS;
				res_d.accepted = enq_ok || (req_q.command == lncs_pkg::CMD_FLUSH);
				res_d.last     = 1'b1;
			end
			lncs_pkg::EMIT_HI: begin
				res_d.kind    = lncs_pkg::KIND_NIBBLE;
				res_d.rs_line = rd_q.rs;
				res_d.nibble  = rd_q.val[7:4];
			end
			lncs_pkg::EMIT_LO: begin
				res_d.kind    = lncs_pkg::KIND_NIBBLE;
				res_d.rs_line = rd_q.rs;
				res_d.nibble  = rd_q.val[3:0];
			end
			lncs_pkg::EMIT_END: begin
				res_d.kind = lncs_pkg::KIND_END;
				res_d.last = 1'b1;
			end
			default: begin
				res_d.kind = lncs_pkg::KIND_STATUS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			strobe_q <= (ctrl.emit != lncs_pkg::EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch_req) begin
			req_q <= request;
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.fetch) begin
			rd_q <= mem[head_q];
		end
		result_q <= res_d;
	end

	assign stat.is_tick   = (req_q.command == lncs_pkg::CMD_TICK);
	assign stat.empty     = (count_q == '0);
	assign stat.task_kind = rd_q.kind;
	assign stat.wait_zero = (rd_q.val == 16'd0);
	assign stat.two       = rd_q.two;
	assign stat.busy_flag = req_q.busy_flag;

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

/* design/lncs_controller.sv */
module lncs_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lncs_pkg::stat_t stat,
	output lncs_pkg::ctrl_t ctrl,
	output logic            busy
);

	lncs_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lncs_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lncs_pkg::ST_DECODE;
				end
			end
			lncs_pkg::ST_DECODE: begin
				state_d = stat.is_tick ? lncs_pkg::ST_CHECK : lncs_pkg::ST_IDLE;
			end
			lncs_pkg::ST_CHECK: begin
				state_d = stat.empty ? lncs_pkg::ST_IDLE : lncs_pkg::ST_EXEC;
			end
			lncs_pkg::ST_EXEC: begin
				case (stat.task_kind)
					lncs_pkg::TASK_WAIT: begin
						state_d = stat.wait_zero ? lncs_pkg::ST_CHECK : lncs_pkg::ST_IDLE;
					end
					lncs_pkg::TASK_BUSY: begin
						state_d = stat.busy_flag ? lncs_pkg::ST_IDLE : lncs_pkg::ST_CHECK;
					end
					default: begin
						state_d = stat.two ? lncs_pkg::ST_LOW : lncs_pkg::ST_CHECK;
					end
				endcase
			end
			lncs_pkg::ST_LOW: begin
				state_d = lncs_pkg::ST_CHECK;
			end
			default: begin
				state_d = lncs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '{latch_req: 1'b0, do_cmd: 1'b0, fetch: 1'b0, pop: 1'b0,
			dec_wait: 1'b0, emit: lncs_pkg::EMIT_NONE};
		case (state_q)
			lncs_pkg::ST_IDLE: begin
				ctrl.latch_req = start;
			end
			lncs_pkg::ST_DECODE: begin
				if (!stat.is_tick) begin
					ctrl.do_cmd = 1'b1;
					ctrl.emit   = lncs_pkg::EMIT_STATUS;
				end
			end
			lncs_pkg::ST_CHECK: begin
				ctrl.fetch = 1'b1;
				if (stat.empty) begin
					ctrl.emit = lncs_pkg::EMIT_END;
				end
			end
			lncs_pkg::ST_EXEC: begin
				case (stat.task_kind)
					lncs_pkg::TASK_WAIT: begin
						if (stat.wait_zero) begin
							ctrl.pop = 1'b1;
						end else begin
							ctrl.dec_wait = 1'b1;
							ctrl.emit     = lncs_pkg::EMIT_END;
						end
					end
					lncs_pkg::TASK_BUSY: begin
						if (stat.busy_flag) begin
							ctrl.emit = lncs_pkg::EMIT_END;
						end else begin
							ctrl.pop = 1'b1;
						end
					end
					default: begin
						ctrl.pop  = 1'b1;
						ctrl.emit = stat.two ? lncs_pkg::EMIT_HI : lncs_pkg::EMIT_LO;
					end
				endcase
			end
			lncs_pkg::ST_LOW: begin
				ctrl.emit = lncs_pkg::EMIT_LO;
			end
			default: begin
				ctrl.emit = lncs_pkg::EMIT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lncs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != lncs_pkg::ST_IDLE);

endmodule

/* design/lcd_nibble_command_sequencer_core.sv */
// Task sequencer for a character display on a 4-bit bus.
// A command is taken at a rising edge with start high and busy low. Enqueue
// commands (write, wait, busy wait) add a task to a ring queue of
// lncs_pkg::QUEUE_DEPTH entries, or drop it when the queue is full; flush
// empties the queue; tick runs queued tasks from the head until one must stop.
// Every result appears for one cycle on result with strobe high, and the final
// result of a command has last set. The receiver cannot stall the block.
// Enqueue, flush and unknown commands give one status transaction, and busy
// drops in the cycle in which it appears. A tick passes one decode state,
// then a check state that fetches and an execute state per task, plus a low
// state for the low nibble of a two-nibble write. It ends at a check that
// finds the queue empty, or at a wait or busy task that must stop; busy drops
// in the cycle in which the end-of-tick transaction appears. The single read
// port of the task store gives each task a check and an execute state.
// Reset empties the queue at once and returns the controller to idle.
module lcd_nibble_command_sequencer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lncs_pkg::request_t request,
	output logic               strobe,
	output lncs_pkg::result_t  result
);

	lncs_pkg::ctrl_t ctrl;
	lncs_pkg::stat_t stat;

	lncs_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	lncs_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctrl    (ctrl),
		.stat    (stat),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

/* design/lncs_checker.sv */
`include "lcd_nibble_command_sequencer_core_assert.svh"

module lncs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               strobe,
	input lncs_pkg::result_t  result
);

	`LNCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "no busy after accept")
	`LNCS_ASSERT_SAME(a_last_idle, strobe, result.last == !busy, "last does not match busy")
	`LNCS_ASSERT_SAME(a_nibble_fields, strobe && (result.kind == lncs_pkg::KIND_NIBBLE),
		!result.last && !result.accepted, "bad nibble transaction")
	`LNCS_ASSERT_SAME(a_pending_range, strobe, result.pending <= lncs_pkg::QUEUE_DEPTH,
		"pending beyond depth")

endmodule

bind lcd_nibble_command_sequencer_core lncs_checker u_lncs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.result  (result)
);
